>>> design/wsfr_pkg.sv
package wsfr_pkg;

  localparam int LEN_BITS = 32;

  localparam logic [2:0] PH_START   = 3'd0;
  localparam logic [2:0] PH_LEN7    = 3'd1;
  localparam logic [2:0] PH_EXTLEN  = 3'd2;
  localparam logic [2:0] PH_MASK    = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_EMPTY   = 2'd1;
  localparam logic [1:0] KIND_BAD     = 2'd2;

  localparam logic [7:0] OP_TEXT   = 8'h81;
  localparam logic [7:0] OP_BINARY = 8'h82;
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  localparam logic [2:0] EXT16_BYTES_M1 = 3'd1;
  localparam logic [2:0] EXT64_BYTES_M1 = 3'd7;
  localparam logic [2:0] MASK_BYTES_M1  = 3'd3;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic       last;
    logic       is_binary;
  } wsfr_result_t;

endpackage

>>> design/wsfr_in_stage.sv
module wsfr_in_stage
  import wsfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       advance,
  output logic       byte_valid,
  output logic [7:0] byte_data
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;

  assign in_ready   = !valid_r || advance;
  assign byte_valid = valid_r;
  assign byte_data  = byte_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_rx_byte;
    end
  end

endmodule

>>> design/wsfr_parser.sv
module wsfr_parser
  import wsfr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step,
  input  logic [7:0]   rx_byte,
  output logic         has_result,
  output wsfr_result_t result
);

  logic [2:0]          phase_r, phase_nxt;
  logic [2:0]          header_count_r, header_count_nxt;
  logic [LEN_BITS-1:0] length_accum_r, length_accum_nxt;
  logic [31:0]         mask_key_r, mask_key_nxt;
  logic [LEN_BITS-1:0] remaining_r, remaining_nxt;
  logic [1:0]          mask_pos_r, mask_pos_nxt;
  logic                binary_r, binary_nxt;

  logic [LEN_BITS-1:0] rem_dec;
  logic [7:0]          key_byte;

  assign rem_dec = remaining_r - {{(LEN_BITS-1){1'b0}}, 1'b1};

  always_comb begin
    case (mask_pos_r)
      2'd0:    key_byte = mask_key_r[31:24];
      2'd1:    key_byte = mask_key_r[23:16];
      2'd2:    key_byte = mask_key_r[15:8];
      default: key_byte = mask_key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt        = phase_r;
    header_count_nxt = header_count_r;
    length_accum_nxt = length_accum_r;
    mask_key_nxt     = mask_key_r;
    remaining_nxt    = remaining_r;
    mask_pos_nxt     = mask_pos_r;
    binary_nxt       = binary_r;
    has_result       = 1'b0;
    result           = '0;
    case (phase_r)
      PH_LEN7: begin
        mask_key_nxt = '0;
        if (rx_byte[6:0] == LEN_EXT16) begin
          length_accum_nxt = '0;
          header_count_nxt = EXT16_BYTES_M1;
          phase_nxt        = PH_EXTLEN;
        end else if (rx_byte[6:0] == LEN_EXT64) begin
          length_accum_nxt = '0;
          header_count_nxt = EXT64_BYTES_M1;
          phase_nxt        = PH_EXTLEN;
        end else begin
          length_accum_nxt = {{(LEN_BITS-7){1'b0}}, rx_byte[6:0]};
          header_count_nxt = '0;
          phase_nxt        = PH_MASK;
        end
      end
      PH_EXTLEN: begin
        // big-endian shift, only the low bits survive
        length_accum_nxt = {length_accum_r[LEN_BITS-9:0], rx_byte};
        if (header_count_r == 3'd0) begin
          phase_nxt = PH_MASK;
        end else begin
          header_count_nxt = header_count_r - 3'd1;
        end
      end
      PH_MASK: begin
        mask_key_nxt = {mask_key_r[23:0], rx_byte};
        if (header_count_r >= MASK_BYTES_M1) begin
          header_count_nxt = '0;
          remaining_nxt    = length_accum_r;
          mask_pos_nxt     = '0;
          if (length_accum_r == '0) begin
            phase_nxt        = PH_START;
            has_result       = 1'b1;
            result.kind      = KIND_EMPTY;
            result.last      = 1'b1;
            result.is_binary = binary_r;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end else begin
          header_count_nxt = header_count_r + 3'd1;
        end
      end
      PH_PAYLOAD: begin
        remaining_nxt    = rem_dec;
        mask_pos_nxt     = mask_pos_r + 2'd1;
        has_result       = 1'b1;
        result.data      = rx_byte ^ key_byte;
        result.kind      = KIND_PAYLOAD;
        result.last      = (rem_dec == '0);
        result.is_binary = binary_r;
        if (rem_dec == '0) begin
          phase_nxt = PH_START;
        end
      end
      default: begin
        if (rx_byte == OP_TEXT || rx_byte == OP_BINARY) begin
          binary_nxt = (rx_byte == OP_BINARY);
          phase_nxt  = PH_LEN7;
        end else begin
          phase_nxt   = PH_START;
          has_result  = 1'b1;
          result.kind = KIND_BAD;
          result.last = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_START;
      header_count_r <= '0;
      length_accum_r <= '0;
      mask_key_r     <= '0;
      remaining_r    <= '0;
      mask_pos_r     <= '0;
      binary_r       <= 1'b0;
    end else if (step) begin
      phase_r        <= phase_nxt;
      header_count_r <= header_count_nxt;
      length_accum_r <= length_accum_nxt;
      mask_key_r     <= mask_key_nxt;
      remaining_r    <= remaining_nxt;
      mask_pos_r     <= mask_pos_nxt;
      binary_r       <= binary_nxt;
    end
  end

`ifndef SYNTHESIS
  a_payload_phase: assert property (@(posedge clk) disable iff (!rst_n)
    step && has_result && result.kind == KIND_PAYLOAD |-> phase_r == PH_PAYLOAD)
    else $error("payload result outside payload phase");

  a_payload_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> remaining_r != '0)
    else $error("payload phase with no bytes left");

  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    step && has_result && result.last |=> phase_r == PH_START)
    else $error("frame end did not return to start");
`endif

endmodule

>>> design/wsfr_out_stage.sv
module wsfr_out_stage
  import wsfr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         load,
  input  wsfr_result_t result,
  output logic         slot_free,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [7:0]   out_data,
  output logic [1:0]   out_kind,
  output logic         out_last,
  output logic         out_is_binary
);

  logic         valid_r, valid_nxt;
  wsfr_result_t result_r;

  assign slot_free     = !valid_r || out_ready;
  assign out_valid     = valid_r;
  assign out_data      = result_r.data;
  assign out_kind      = result_r.kind;
  assign out_last      = result_r.last;
  assign out_is_binary = result_r.is_binary;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result;
    end
  end

endmodule

>>> design/websocket_frame_receiver.sv
// websocket frame receiver: takes client-to-server frames one byte per transfer and
// gives one result per payload byte (unmasked, last byte marked), one result for an
// empty frame, or one error result for a start byte other than 0x81/0x82. header
// bytes give no result. the byte passes an input register, combinational parsing logic
// and a result register; a new byte is taken every cycle as long as the result
// register drains; 64-bit lengths keep their low 32 bits.
module websocket_frame_receiver
  import wsfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_data,
  output logic [1:0] out_kind,
  output logic       out_last,
  output logic       out_is_binary
);

  logic         byte_valid;
  logic [7:0]   byte_data;
  logic         has_result;
  wsfr_result_t result;
  logic         slot_free;
  logic         advance;

  // header bytes move on even when the result register is full
  assign advance = byte_valid && (!has_result || slot_free);

  wsfr_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .advance    (advance),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  wsfr_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .rx_byte    (byte_data),
    .has_result (has_result),
    .result     (result)
  );

  wsfr_out_stage u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (advance && has_result),
    .result        (result),
    .slot_free     (slot_free),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .out_kind      (out_kind),
    .out_last      (out_last),
    .out_is_binary (out_is_binary)
  );

endmodule

>>> tb/sv/websocket_frame_receiver_test.sv
`timescale 1ns / 1ps

module websocket_frame_receiver_test;
  import wsfr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_BYTES = 290;
  localparam int SETTLE_CYCLES = 20;

  typedef enum int {LEN_FORM_SHORT, LEN_FORM_16, LEN_FORM_64} len_form_e;

  // tracks the deframer state and queues the result each accepted byte should give
  class frame_unmask_board;
    logic [2:0]          frame_phase;
    logic [2:0]          hdr_cnt;
    logic [LEN_BITS-1:0] len_acc;
    logic [31:0]         mask_word;
    logic [LEN_BITS-1:0] bytes_left;
    logic [1:0]          mask_idx;
    logic                bin_frame;
    wsfr_result_t        expected_results[$];
    int                  mismatches;

    function new();
      frame_phase = PH_START;
      hdr_cnt = '0;
      len_acc = '0;
      mask_word = '0;
      bytes_left = '0;
      mask_idx = '0;
      bin_frame = 1'b0;
      mismatches = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void take_byte(logic [7:0] b);
      logic [7:0]   key_byte;
      wsfr_result_t res;
      case (frame_phase)
        PH_LEN7: begin
          len_acc = '0;
          mask_word = '0;
          if (b[6:0] == LEN_EXT16) begin
            hdr_cnt = EXT16_BYTES_M1;
            frame_phase = PH_EXTLEN;
          end else if (b[6:0] == LEN_EXT64) begin
            hdr_cnt = EXT64_BYTES_M1;
            frame_phase = PH_EXTLEN;
          end else begin
            len_acc = {{(LEN_BITS-7){1'b0}}, b[6:0]};
            hdr_cnt = '0;
            frame_phase = PH_MASK;
          end
        end
        PH_EXTLEN: begin
          // upper bytes of a long length fall off the top
          len_acc = {len_acc[LEN_BITS-9:0], b};
          if (hdr_cnt == '0) begin
            frame_phase = PH_MASK;
          end else begin
            hdr_cnt = hdr_cnt - 3'd1;
          end
        end
        PH_MASK: begin
          mask_word = {mask_word[23:0], b};
          if (hdr_cnt >= MASK_BYTES_M1) begin
            hdr_cnt = '0;
            bytes_left = len_acc;
            mask_idx = '0;
            if (bytes_left == '0) begin
              frame_phase = PH_START;
              res = '{data: 8'h00, kind: KIND_EMPTY, last: 1'b1, is_binary: bin_frame};
              expected_results.push_back(res);
            end else begin
              frame_phase = PH_PAYLOAD;
            end
          end else begin
            hdr_cnt = hdr_cnt + 3'd1;
          end
        end
        PH_PAYLOAD: begin
          key_byte = mask_word[8*(3-mask_idx) +: 8];
          bytes_left = bytes_left - {{(LEN_BITS-1){1'b0}}, 1'b1};
          mask_idx = mask_idx + 2'd1;
          if (bytes_left == '0) frame_phase = PH_START;
          res = '{data: b ^ key_byte, kind: KIND_PAYLOAD, last: (bytes_left == '0),
                  is_binary: bin_frame};
          expected_results.push_back(res);
        end
        default: begin
          if (b == OP_TEXT || b == OP_BINARY) begin
            bin_frame = (b == OP_BINARY);
            frame_phase = PH_LEN7;
          end else begin
            frame_phase = PH_START;
            res = '{data: 8'h00, kind: KIND_BAD, last: 1'b1, is_binary: 1'b0};
            expected_results.push_back(res);
          end
        end
      endcase
    endfunction

    function void match_result(logic [7:0] data, logic [1:0] kind, logic last, logic bin);
      wsfr_result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result data=%h kind=%0d last=%b is_binary=%b",
                 $time, data, kind, last, bin);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      if (data !== want.data) begin
        $display("%0t: data expected %h got %h", $time, want.data, data);
        mismatches++;
      end
      if (kind !== want.kind) begin
        $display("%0t: kind expected %0d got %0d", $time, want.kind, kind);
        mismatches++;
      end
      if (last !== want.last) begin
        $display("%0t: last expected %b got %b", $time, want.last, last);
        mismatches++;
      end
      if (bin !== want.is_binary) begin
        $display("%0t: is_binary expected %b got %b", $time, want.is_binary, bin);
        mismatches++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_data;
  logic [1:0] out_kind;
  logic       out_last;
  logic       out_is_binary;

  frame_unmask_board unmask_board = new();
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_req = 1'b0;
  int  bytes_sent = 0;
  int  cycle_count = 0;

  websocket_frame_receiver u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_rx_byte   (in_rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .out_kind     (out_kind),
    .out_last     (out_last),
    .out_is_binary(out_is_binary)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    unmask_board.take_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] opcode, input len_form_e form,
                            input logic [63:0] len, input logic [31:0] key);
    int unsigned count;
    send_byte(opcode);
    // mask flag in the length byte is random, the block ignores it
    case (form)
      LEN_FORM_16: begin
        send_byte({1'($urandom_range(1)), LEN_EXT16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        count = 32'(len[15:0]);
      end
      LEN_FORM_64: begin
        send_byte({1'($urandom_range(1)), LEN_EXT64});
        for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
        count = len[LEN_BITS-1:0];
      end
      default: begin
        send_byte({1'($urandom_range(1)), len[6:0]});
        count = 32'(len[6:0]);
      end
    endcase
    for (int i = 3; i >= 0; i--) send_byte(key[8*i +: 8]);
    repeat (count) send_byte(8'($urandom));
  endtask

  task automatic random_unit();
    int          pick;
    int          s;
    logic [7:0]  b;
    logic [63:0] len;
    logic [31:0] key;
    len_form_e   form;
    pick = $urandom_range(99);
    if (pick < 12) begin
      // stray bytes between frames, never a valid opcode so each one is rejected
      repeat ($urandom_range(1, 4)) begin
        do b = 8'($urandom); while (b == OP_TEXT || b == OP_BINARY);
        send_byte(b);
      end
    end else begin
      s = $urandom_range(29);
      pick = $urandom_range(99);
      if (pick < 60) begin
        form = LEN_FORM_SHORT;
        len = (s == 0) ? 64'd125 : (s < 4) ? 64'd0 : 64'($urandom_range(1, 12));
      end else if (pick < 80) begin
        form = LEN_FORM_16;
        len = (s == 0) ? 64'($urandom_range(126, 300)) :
              (s < 4) ? 64'd0 : 64'($urandom_range(1, 16));
      end else begin
        form = LEN_FORM_64;
        len[31:0] = (s < 4) ? 32'd0 : 32'($urandom_range(1, 16));
        len[63:32] = (s == 5) ? 32'd0 : 32'($urandom);
      end
      case ($urandom_range(9))
        0:       key = 32'h0000_0000;
        1:       key = 32'hFFFF_FFFF;
        default: key = $urandom;
      endcase
      send_frame($urandom_range(1) ? OP_BINARY : OP_TEXT, form, len, key);
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (unmask_board.pending() != 0);
  endtask

  // result side: random stalls, with one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      unmask_board.match_result(out_data, out_kind, out_last, out_is_binary);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int goal;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_rx_byte = 8'h00;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(OP_TEXT, LEN_FORM_SHORT, 64'd0, 32'h0000_0000);
    // high word of a 64-bit length is dropped, one payload byte
    send_frame(OP_BINARY, LEN_FORM_64, 64'hFFFF_FFFF_0000_0001, 32'h5A3C_0FF0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          hold_req = 1'b1;
        end
        1: begin
          send_idle_pct = 61;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 61;
        end
        default: begin
          send_idle_pct = 23;
          recv_stall_pct = 23;
        end
      endcase
      goal = bytes_sent + PHASE_BYTES;
      while (bytes_sent < goal) random_unit();
      wait_for_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (unmask_board.mismatches == 0 && unmask_board.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
